>>> rtl/core/hcbp_pkg.sv
// hcbp_pkg: shared types and constants for the huffman code bit packer
// no dependencies; used by every file in rtl/core except hcbp_checker

package hcbp_pkg;

   localparam int CODE_W      = 32;
   localparam int LEN_W       = 6;
   localparam int SYM_W       = 8;
   localparam int OP_W        = 2;
   localparam int BYTE_W      = 8;
   localparam int ACC_W       = CODE_W + BYTE_W - 1;
   localparam int CNT_W       = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } hcbp_op_type;

   typedef struct packed {
      logic              flush;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } hcbp_cmd_type;

endpackage

>>> rtl/core/hcbp_if.sv
// hcbp_req_if and hcbp_rsp_if: valid/ready channels of the packer
// depends on hcbp_pkg for field widths

interface hcbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [hcbp_pkg::OP_W-1:0]    operation;
   logic [hcbp_pkg::SYM_W-1:0]   symbol;
   logic [hcbp_pkg::LEN_W-1:0]   code_length;
   logic [hcbp_pkg::CODE_W-1:0]  code_bits;

   modport source (output valid, output operation, output symbol, output code_length,
                   output code_bits, input ready);
   modport sink   (input valid, input operation, input symbol, input code_length,
                   input code_bits, output ready);
endinterface

interface hcbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
   logic                         last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/core/hcbp_front.sv
// hcbp_front: accepts transactions, holds the code table, classifies items
// depends on hcbp_pkg and hcbp_req_if

module hcbp_front #(
   parameter int MAX_CODE_LEN = 32,
   parameter int NUM_SYMBOLS  = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   hcbp_req_if.sink              req_chan,
   output logic                  cmd_valid,
   output hcbp_pkg::hcbp_cmd_type cmd,
   input  logic                  cmd_ready
);

   localparam int IDX_W = $clog2(NUM_SYMBOLS);
   localparam int CAP   = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;

   logic [hcbp_pkg::CODE_W-1:0] code_mem [NUM_SYMBOLS];
   logic [hcbp_pkg::LEN_W-1:0]  len_mem  [NUM_SYMBOLS];

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_flush_ff;
   logic [hcbp_pkg::CODE_W-1:0] rd_code_ff;
   logic [hcbp_pkg::LEN_W-1:0]  rd_len_ff;

   logic                        advance, accept, in_range, is_load, is_encode, is_flush;
   logic [IDX_W-1:0]            idx;
   logic [hcbp_pkg::LEN_W-1:0]  len_eff;
   logic [hcbp_pkg::CODE_W:0]   len_mask;

   assign idx       = req_chan.symbol[IDX_W-1:0];
   assign in_range  = {1'b0, req_chan.symbol} < (hcbp_pkg::SYM_W+1)'(NUM_SYMBOLS);
   assign is_load   = req_chan.operation == hcbp_pkg::OP_LOAD;
   assign is_encode = req_chan.operation == hcbp_pkg::OP_ENCODE;
   assign is_flush  = req_chan.operation == hcbp_pkg::OP_FLUSH;

   assign advance        = !s1_valid_ff || cmd_ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign s1_valid_in    = accept && ((is_encode && in_range) || is_flush);

   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         code_mem[idx] <= req_chan.code_bits;
         len_mem[idx]  <= req_chan.code_length;
      end
      if (advance) begin
         rd_code_ff  <= code_mem[idx];
         rd_len_ff   <= len_mem[idx];
         s1_flush_ff <= is_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // saturate long codes and drop bits above the length
   always_comb begin
      len_eff  = (rd_len_ff > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP) : rd_len_ff;
      len_mask = ((hcbp_pkg::CODE_W+1)'(1) << len_eff) - (hcbp_pkg::CODE_W+1)'(1);
   end

   assign cmd_valid  = s1_valid_ff;
   assign cmd.flush  = s1_flush_ff;
   assign cmd.len    = len_eff;
   assign cmd.code   = rd_code_ff & len_mask[hcbp_pkg::CODE_W-1:0];

endmodule

>>> rtl/core/hcbp_queue.sv
// hcbp_queue: short command queue between the front and the packer
// depends on hcbp_pkg

module hcbp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  hcbp_pkg::hcbp_cmd_type push_cmd,
   output logic                   push_ready,
   output logic                   pop_valid,
   output hcbp_pkg::hcbp_cmd_type pop_cmd,
   input  logic                   pop_ready
);

   hcbp_pkg::hcbp_cmd_type        slot_ff [hcbp_pkg::QUEUE_DEPTH];
   logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::QPTR_W:0]     count_ff, count_in;
   logic                          push, pop;

   assign push_ready = count_ff != (hcbp_pkg::QPTR_W+1)'(hcbp_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (hcbp_pkg::QPTR_W+1)'(push) - (hcbp_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/hcbp_packer.sv
// hcbp_packer: bit accumulator and byte emitter with output register
// depends on hcbp_pkg and hcbp_rsp_if

module hcbp_packer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  hcbp_pkg::hcbp_cmd_type cmd,
   output logic                   cmd_ready,
   hcbp_rsp_if.source             rsp_chan
);

   logic [hcbp_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [hcbp_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        out_free, draining, emit;
   logic [hcbp_pkg::ACC_W-1:0]  sum_acc;
   logic [hcbp_pkg::CNT_W-1:0]  sum_cnt;
   logic [3:0]                  pad_amt;

   localparam logic [hcbp_pkg::CNT_W-1:0] ONE_BYTE = hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
   localparam logic [hcbp_pkg::CNT_W-1:0] TWO_BYTE = hcbp_pkg::CNT_W'(2 * hcbp_pkg::BYTE_W);

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign draining  = cnt_ff >= ONE_BYTE;
   assign cmd_ready = out_free && !draining;

   always_comb begin
      sum_acc = (acc_ff << cmd.len) | hcbp_pkg::ACC_W'(cmd.code);
      sum_cnt = cnt_ff + cmd.len;
      pad_amt = 4'(hcbp_pkg::BYTE_W) - {1'b0, cnt_ff[2:0]};

      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      emit        = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;

      if (out_free) begin
         if (draining) begin
            emit        = 1'b1;
            rsp_byte_in = hcbp_pkg::BYTE_W'(acc_ff >> (cnt_ff - ONE_BYTE));
            rsp_last_in = cnt_ff < TWO_BYTE;
            cnt_in      = cnt_ff - ONE_BYTE;
         end else if (cmd_valid) begin
            if (cmd.flush) begin
               emit        = cnt_ff != '0;
               rsp_byte_in = hcbp_pkg::BYTE_W'(acc_ff[hcbp_pkg::BYTE_W-1:0] << pad_amt);
               rsp_last_in = 1'b1;
               cnt_in      = '0;
            end else begin
               acc_in = sum_acc;
               if (sum_cnt >= ONE_BYTE) begin
                  emit        = 1'b1;
                  rsp_byte_in = hcbp_pkg::BYTE_W'(sum_acc >> (sum_cnt - ONE_BYTE));
                  rsp_last_in = sum_cnt < TWO_BYTE;
                  cnt_in      = sum_cnt - ONE_BYTE;
               end else begin
                  cnt_in = sum_cnt;
               end
            end
         end
      end

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

>>> rtl/core/huffman_code_bit_packer.sv
// huffman_code_bit_packer: top level, front, command queue and packer
// depends on hcbp_pkg, hcbp_if, hcbp_front, hcbp_queue, hcbp_packer

// Load transactions write one code table entry; encode and flush
// transactions read the table (one registered read), pass through a four-entry
// command queue and reach the packer, whose output register holds each byte.
// The packer's output register emits one byte per cycle while rsp_chan.ready
// is high; an item that completes several bytes holds the packer until all are
// emitted, and meanwhile the queue and then req_chan.ready apply backpressure.
// The table has no reset and needs no clearing pass; encoding a never-loaded
// symbol gives undefined bytes.

module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int NUM_SYMBOLS  = 256
) (
   input  logic       clock,
   input  logic       reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   logic                   front_valid, front_ready;
   hcbp_pkg::hcbp_cmd_type front_cmd;
   logic                   back_valid, back_ready;
   hcbp_pkg::hcbp_cmd_type back_cmd;

   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .NUM_SYMBOLS  (NUM_SYMBOLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   hcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_cmd   (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_cmd    (back_cmd),
      .pop_ready  (back_ready)
   );

   hcbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd       (back_cmd),
      .cmd_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> rtl/core/hcbp_checker.sv
// hcbp_checker: port-level assertions for huffman_code_bit_packer
// depends on huffman_code_bit_packer; attached by the bind below

module hcbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp transaction straight after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready straight after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

>>> tb/sv/tb_huffman_code_bit_packer.sv
// tb_huffman_code_bit_packer: self-checking bench for the huffman code bit packer
// loads code tables, encodes and flushes under random idling, checks every packed byte
// depends on hcbp_pkg, hcbp_if and huffman_code_bit_packer from rtl/core

module tb_huffman_code_bit_packer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CODE_LEN = 32;
   localparam int NUM_SYMBOLS  = 256;
   localparam int LEN_CAP      = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                   : hcbp_pkg::CODE_W;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 16;
   localparam logic [hcbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [hcbp_pkg::OP_W-1:0]   op;
      logic [hcbp_pkg::SYM_W-1:0]  symbol;
      logic [hcbp_pkg::LEN_W-1:0]  len;
      logic [hcbp_pkg::CODE_W-1:0] code;
   } code_item_type;

   typedef struct {
      logic [hcbp_pkg::BYTE_W-1:0] data;
      logic                        last;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcbp_req_if req_if ();
   hcbp_rsp_if rsp_if ();

   huffman_code_bit_packer #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .NUM_SYMBOLS  (NUM_SYMBOLS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   code_item_type   queued_items[$];
   packed_byte_type expected_bytes[$];
   logic [hcbp_pkg::CODE_W-1:0] code_table [NUM_SYMBOLS];
   logic [hcbp_pkg::LEN_W-1:0]  length_table [NUM_SYMBOLS];
   logic [6:0]                  partial_bits = '0;
   logic [2:0]                  partial_count = '0;
   bit                          is_loaded [NUM_SYMBOLS];
   logic [hcbp_pkg::SYM_W-1:0]  loaded_syms[$];
   int unsigned                 send_idle_pct = 0;
   int unsigned                 recv_idle_pct = 0;
   int unsigned                 errors = 0;
   int unsigned                 cycle_count = 0;
   bit                          req_taken = 1'b0;
   code_item_type               next_item;
   code_item_type               seen_item;
   packed_byte_type             want;

   // bit-accurate model of the table, accumulator and byte emission
   task automatic predict_packed_bytes(input code_item_type it);
      logic [63:0]     acc;
      int unsigned     n;
      int unsigned     len;
      packed_byte_type pb;
      case (it.op)
         hcbp_pkg::OP_LOAD: begin
            code_table[it.symbol]   = it.code;
            length_table[it.symbol] = it.len;
         end
         hcbp_pkg::OP_ENCODE: begin
            len = 32'(length_table[it.symbol]);
            if (len > LEN_CAP) len = LEN_CAP;
            n   = 32'(partial_count);
            acc = 64'(partial_bits);
            acc = (acc << len) | (64'(code_table[it.symbol]) & ((64'd1 << len) - 64'd1));
            n   = n + len;
            while (n >= hcbp_pkg::BYTE_W) begin
               n       = n - hcbp_pkg::BYTE_W;
               pb.data = acc[n +: hcbp_pkg::BYTE_W];
               pb.last = (n < hcbp_pkg::BYTE_W);
               expected_bytes.push_back(pb);
            end
            partial_bits  = 7'(acc & ((64'd1 << n) - 64'd1));
            partial_count = 3'(n);
         end
         hcbp_pkg::OP_FLUSH: begin
            if (partial_count != 0) begin
               pb.data = 8'({1'b0, partial_bits} << (hcbp_pkg::BYTE_W - partial_count));
               pb.last = 1'b1;
               expected_bytes.push_back(pb);
            end
            partial_bits  = '0;
            partial_count = '0;
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [hcbp_pkg::OP_W-1:0] op,
                            input logic [hcbp_pkg::SYM_W-1:0] sym,
                            input logic [hcbp_pkg::LEN_W-1:0] len,
                            input logic [hcbp_pkg::CODE_W-1:0] code);
      code_item_type it;
      it.op     = op;
      it.symbol = sym;
      it.len    = len;
      it.code   = code;
      if (op == hcbp_pkg::OP_LOAD && !is_loaded[sym]) begin
         is_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
      queued_items.push_back(it);
   endtask

   // mostly encodes of loaded symbols, with table reloads, flushes and a little noise
   task automatic add_random_items(input int count);
      int made;
      int unsigned r;
      int unsigned lr;
      logic [hcbp_pkg::LEN_W-1:0] len;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < 4) begin
            push_item(OP_UNUSED, hcbp_pkg::SYM_W'($urandom), hcbp_pkg::LEN_W'($urandom),
                      $urandom);
         end else begin
            if (r < 24) begin
               lr = $urandom_range(99);
               if (lr < 8) len = '0;
               else if (lr < 16) len = hcbp_pkg::LEN_W'($urandom_range(63, 33));
               else if (lr < 60) len = hcbp_pkg::LEN_W'($urandom_range(8, 1));
               else len = hcbp_pkg::LEN_W'($urandom_range(32, 9));
               push_item(hcbp_pkg::OP_LOAD, hcbp_pkg::SYM_W'($urandom), len, $urandom);
            end else if (r < 88) begin
               push_item(hcbp_pkg::OP_ENCODE,
                         loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                         hcbp_pkg::LEN_W'($urandom), $urandom);
            end else begin
               push_item(hcbp_pkg::OP_FLUSH, hcbp_pkg::SYM_W'($urandom),
                         hcbp_pkg::LEN_W'($urandom), $urandom);
            end
            made++;
         end
      end
   endtask

   task automatic wait_items_taken();
      while (queued_items.size() != 0 || req_if.valid) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_if.valid || req_taken) begin
            req_taken = 1'b0;
            if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = queued_items.pop_front();
               req_if.operation   <= next_item.op;
               req_if.symbol      <= next_item.symbol;
               req_if.code_length <= next_item.len;
               req_if.code_bits   <= next_item.code;
               req_if.valid       <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen_item.op     = req_if.operation;
            seen_item.symbol = req_if.symbol;
            seen_item.len    = req_if.code_length;
            seen_item.code   = req_if.code_bits;
            predict_packed_bytes(seen_item);
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t unexpected transaction: expected none, actual byte %h last %b",
                        $time, rsp_if.out_byte, rsp_if.last_of_run);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  $display("%0t out_byte mismatch: expected %h, actual %h",
                           $time, want.data, rsp_if.out_byte);
                  errors++;
               end
               if (rsp_if.last_of_run !== want.last) begin
                  $display("%0t last_of_run mismatch: expected %b, actual %b",
                           $time, want.last, rsp_if.last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.operation   = hcbp_pkg::OP_LOAD;
      req_if.symbol      = '0;
      req_if.code_length = '0;
      req_if.code_bits   = '0;
      rsp_if.ready       = 1'b0;
      send_idle_pct      = 18;
      recv_idle_pct      = 64;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table entries: shortest and longest codes, zero length, saturating lengths,
      // code bits set above the length
      push_item(hcbp_pkg::OP_LOAD, 8'h00, 6'd1,  32'h0000_0001);
      push_item(hcbp_pkg::OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
      push_item(hcbp_pkg::OP_LOAD, 8'h80, 6'd8,  32'h0000_00A5);
      push_item(hcbp_pkg::OP_LOAD, 8'h01, 6'd0,  32'hDEAD_BEEF);
      push_item(hcbp_pkg::OP_LOAD, 8'h02, 6'd63, 32'h8000_0001);
      push_item(hcbp_pkg::OP_LOAD, 8'h03, 6'd5,  32'hFFFF_FFE6);
      push_item(hcbp_pkg::OP_LOAD, 8'h55, 6'd7,  32'h0000_0055);
      push_item(hcbp_pkg::OP_LOAD, 8'hAA, 6'd33, 32'h1234_5678);
      push_item(hcbp_pkg::OP_ENCODE, 8'h00, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'hFF, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h80, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h01, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h02, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'hAA, '0, '0);
      push_item(hcbp_pkg::OP_FLUSH,  8'h00, '0, '0);
      push_item(hcbp_pkg::OP_FLUSH,  8'hFF, 6'h3F, 32'hFFFF_FFFF);
      push_item(OP_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
      // seven bits pending then a full-width code
      push_item(hcbp_pkg::OP_ENCODE, 8'h55, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'hFF, '0, '0);
      push_item(hcbp_pkg::OP_FLUSH,  8'h00, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h00, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h55, '0, '0);
      push_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0);
      push_item(hcbp_pkg::OP_FLUSH,  8'h00, '0, '0);
      add_random_items(32);
      wait_items_taken();

      send_idle_pct = 64;
      recv_idle_pct = 18;
      add_random_items(32);
      wait_items_taken();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_items(32);
      wait_items_taken();

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_if.sv
rtl/core/hcbp_front.sv
rtl/core/hcbp_queue.sv
rtl/core/hcbp_packer.sv
rtl/core/huffman_code_bit_packer.sv
rtl/core/hcbp_checker.sv
tb/sv/tb_huffman_code_bit_packer.sv
